FILE: hw/rtl/cif_pkg.sv
// ---------------------------------------------------------------------------
// cif_pkg
// Shared widths, register indexes and stage types for the integrate-and-fire
// aggregation block.
// ---------------------------------------------------------------------------
package cif_pkg;

    localparam int ALPHA_W    = 16;
    localparam int HID_W      = 16;
    localparam int POS_W      = 8;
    localparam int THR_W      = 16;
    localparam int MASK_W     = 8;
    localparam int CHUNK_W    = 9;
    localparam int INTEG_W    = 19;
    localparam int FACT_W     = 20;
    localparam int TOTAL_W    = 32;
    localparam int EMB_W      = 40;
    localparam int OUT_IDX_W  = 9;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MASKED    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MASKED   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_FRAMES   = 8'd3;

    typedef struct packed {
        logic [THR_W-1:0]   fire_threshold;
        logic [MASK_W-1:0]  left_masked;
        logic [MASK_W-1:0]  right_masked;
        logic [CHUNK_W-1:0] chunk_frames;
    } cif_cfg_t;

    // One element after the scalar decision, on its way to the MAC stage
    typedef struct packed {
        logic                      fire;
        logic                      fend;
        logic                      pend_valid;
        logic signed [FACT_W-1:0]  factor;
        logic signed [INTEG_W-1:0] resid;
        logic [TOTAL_W-1:0]        total;
        logic signed [HID_W-1:0]   hidden;
    } cif_item_t;

endpackage

FILE: hw/rtl/cif_front.sv
// ---------------------------------------------------------------------------
// cif_front
// Input stage: edge masking, fire decision, integral / fired-sum / counter
// state and the pending-entry fill count, registered into stage 1.
// ---------------------------------------------------------------------------
module cif_front #(
    parameter int HIDDEN_SIZE = 512,
    parameter int IDX_W       = 9,
    parameter int FILL_W      = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cif_pkg::cif_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cif_pkg::ALPHA_W-1:0]   alpha_weight,
    input  logic signed [cif_pkg::HID_W-1:0] hidden_value,
    input  logic [cif_pkg::POS_W-1:0]     frame_pos,
    input  logic                          frame_end,
    input  logic                          restart,
    input  logic                          s1_advance,
    output logic                          s1_valid,
    output cif_pkg::cif_item_t            s1_item,
    output logic [IDX_W-1:0]              s1_idx
);
    import cif_pkg::*;

    localparam logic signed [FACT_W-1:0] INTEG_MAX = FACT_W'(262143);
    localparam logic signed [FACT_W-1:0] INTEG_MIN = -FACT_W'(262144);

    logic                      s1_valid_reg;
    cif_item_t                 s1_item_reg;
    logic [IDX_W-1:0]          s1_idx_reg;

    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    logic [TOTAL_W-1:0]        fired_sum_reg, fired_sum_next;
    logic [IDX_W-1:0]          counter_reg, counter_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;

    logic                      accept;
    logic signed [INTEG_W-1:0] integ;
    logic [TOTAL_W-1:0]        fsum;
    logic [IDX_W-1:0]          idx;
    logic [FILL_W-1:0]         fill;
    logic [FILL_W-1:0]         idx_f;
    logic                      left_hit, right_hit;
    logic [CHUNK_W-1:0]        right_start;
    logic [ALPHA_W-1:0]        a_eff;
    logic signed [FACT_W-1:0]  integ_x, thr_x, sum, need, diff;
    logic signed [INTEG_W-1:0] sum_sat, resid;
    logic signed [TOTAL_W+1:0] total_x;
    logic [TOTAL_W-1:0]        total;
    logic                      fire;

    function automatic logic signed [INTEG_W-1:0] sat19(input logic signed [FACT_W-1:0] x);
        logic signed [INTEG_W-1:0] r;
        if (x > INTEG_MAX)
            r = INTEG_MAX[INTEG_W-1:0];
        else if (x < INTEG_MIN)
            r = INTEG_MIN[INTEG_W-1:0];
        else
            r = x[INTEG_W-1:0];
        return r;
    endfunction

    assign in_ready = !s1_valid_reg || s1_advance;
    assign accept   = in_valid && in_ready;

    // restart acts before the element itself
    assign integ = restart ? '0 : integral_reg;
    assign fsum  = restart ? '0 : fired_sum_reg;
    assign idx   = restart ? '0 : counter_reg;
    assign fill  = restart ? '0 : fill_reg;
    assign idx_f = FILL_W'(idx);

    assign left_hit    = frame_pos < cfg.left_masked;
    assign right_start = cfg.chunk_frames - {1'b0, cfg.right_masked};
    assign right_hit   = (cfg.chunk_frames > {1'b0, cfg.right_masked})
                      && ({1'b0, frame_pos} >= right_start);
    assign a_eff       = (left_hit || right_hit) ? '0 : alpha_weight;

    assign integ_x = {integ[INTEG_W-1], integ};
    assign thr_x   = $signed({4'b0000, cfg.fire_threshold});
    assign sum     = integ_x + $signed({4'b0000, a_eff});
    assign fire    = sum >= thr_x;
    assign need    = thr_x - integ_x;
    assign diff    = sum - thr_x;
    assign sum_sat = sat19(sum);
    assign resid   = sat19(diff);

    // fired sum clamps to the unsigned 32-bit range
    assign total_x = $signed({2'b00, fsum}) + $signed({{(TOTAL_W+2-FACT_W){need[FACT_W-1]}}, need});
    always_comb
    begin
        if (total_x[TOTAL_W+1])
            total = '0;
        else if (total_x[TOTAL_W])
            total = '1;
        else
            total = total_x[TOTAL_W-1:0];
    end

    always_comb
    begin
        integral_next  = integ;
        fired_sum_next = fsum;
        if (frame_end)
        begin
            integral_next = fire ? resid : sum_sat;
            if (fire)
                fired_sum_next = total;
        end
        if (frame_end || (idx_f + 1'b1 == FILL_W'(HIDDEN_SIZE)))
            counter_next = '0;
        else
            counter_next = idx + 1'b1;
        // entries touched since restart always form a prefix of the store
        fill_next = (idx_f == fill) ? fill + 1'b1 : fill;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            fired_sum_reg <= '0;
            counter_reg   <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                integral_reg  <= integral_next;
                fired_sum_reg <= fired_sum_next;
                counter_reg   <= counter_next;
                fill_reg      <= fill_next;
            end
            if (in_ready)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.fire       <= fire;
            s1_item_reg.fend       <= frame_end;
            s1_item_reg.pend_valid <= idx_f < fill;
            s1_item_reg.factor     <= fire ? need : $signed({4'b0000, a_eff});
            s1_item_reg.resid      <= resid;
            s1_item_reg.total      <= total;
            s1_item_reg.hidden     <= hidden_value;
            s1_idx_reg             <= idx;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_idx   = s1_idx_reg;

endmodule

FILE: hw/rtl/cif_mac.sv
// ---------------------------------------------------------------------------
// cif_mac
// Pending-embedding store with registered read, multiply stage, saturating
// accumulate with write-back forwarding, and the result register.
// ---------------------------------------------------------------------------
module cif_mac #(
    parameter int HIDDEN_SIZE = 512,
    parameter int IDX_W       = 9
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s1_valid,
    input  cif_pkg::cif_item_t               s1_item,
    input  logic [IDX_W-1:0]                 s1_idx,
    output logic                             s1_advance,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [cif_pkg::EMB_W-1:0] embedding_value,
    output logic [cif_pkg::OUT_IDX_W-1:0]    element_index,
    output logic                             token_end,
    output logic [cif_pkg::TOTAL_W-1:0]      fired_total,
    output logic signed [cif_pkg::INTEG_W-1:0] residual
);
    import cif_pkg::*;

    localparam int P1_W  = FACT_W + HID_W;
    localparam int P2_W  = INTEG_W + HID_W;
    localparam int EXT_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

    localparam logic signed [EMB_W:0] EMB_MAX = {2'b00, {(EMB_W-1){1'b1}}};
    localparam logic signed [EMB_W:0] EMB_MIN = {2'b11, {(EMB_W-1){1'b0}}};

    logic signed [EMB_W-1:0]   mem [HIDDEN_SIZE];
    logic signed [EMB_W-1:0]   rd_reg;

    logic                      s2_valid_reg;
    logic                      s2_fire_reg, s2_fend_reg, s2_pvalid_reg;
    logic                      s2_fwd_hit_reg;
    logic signed [EMB_W-1:0]   s2_fwd_data_reg;
    logic signed [P1_W-1:0]    s2_p1_reg;
    logic signed [P2_W-1:0]    s2_p2_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic [TOTAL_W-1:0]        s2_total_reg;
    logic signed [INTEG_W-1:0] s2_resid_reg;

    logic                      out_valid_reg;
    logic signed [EMB_W-1:0]   emb_reg;
    logic [EXT_W-1:0]          idx_out_reg;
    logic                      tend_reg;
    logic [TOTAL_W-1:0]        total_out_reg;
    logic signed [INTEG_W-1:0] resid_out_reg;

    logic                      s2_advance, s1_take, wr_en;
    logic signed [P1_W-1:0]    p1;
    logic signed [P2_W-1:0]    p2;
    logic signed [EMB_W-1:0]   pend, emb_sat, wr_data;
    logic signed [EMB_W:0]     emb_x;

    assign s2_advance = !s2_valid_reg || !s2_fire_reg || !out_valid_reg || out_ready;
    assign s1_advance = s2_advance;
    assign s1_take    = s1_valid && s2_advance;
    assign wr_en      = s2_valid_reg && s2_advance;

    assign p1 = s1_item.factor * s1_item.hidden;
    assign p2 = s1_item.resid * s1_item.hidden;

    // an entry not written since restart reads as zero
    assign pend = !s2_pvalid_reg ? '0 : (s2_fwd_hit_reg ? s2_fwd_data_reg : rd_reg);

    assign emb_x = {pend[EMB_W-1], pend} + {{(EMB_W+1-P1_W){s2_p1_reg[P1_W-1]}}, s2_p1_reg};
    always_comb
    begin
        if (emb_x > EMB_MAX)
            emb_sat = EMB_MAX[EMB_W-1:0];
        else if (emb_x < EMB_MIN)
            emb_sat = EMB_MIN[EMB_W-1:0];
        else
            emb_sat = emb_x[EMB_W-1:0];
    end

    assign wr_data = s2_fire_reg ? {{(EMB_W-P2_W){s2_p2_reg[P2_W-1]}}, s2_p2_reg} : emb_sat;

    always_ff @(posedge clk)
    begin
        if (s1_take)
            rd_reg <= mem[s1_idx];
        if (wr_en)
            mem[s2_idx_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_advance)
            s2_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s2_fire_reg     <= s1_item.fire;
            s2_fend_reg     <= s1_item.fend;
            s2_pvalid_reg   <= s1_item.pend_valid;
            // the write leaving now is missed by the read issued at this edge
            s2_fwd_hit_reg  <= wr_en && (s2_idx_reg == s1_idx);
            s2_fwd_data_reg <= wr_data;
            s2_p1_reg       <= p1;
            s2_p2_reg       <= p2;
            s2_idx_reg      <= s1_idx;
            s2_total_reg    <= s1_item.total;
            s2_resid_reg    <= s1_item.resid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (wr_en && s2_fire_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && s2_fire_reg)
        begin
            emb_reg       <= emb_sat;
            idx_out_reg   <= EXT_W'(s2_idx_reg);
            tend_reg      <= s2_fend_reg;
            total_out_reg <= s2_total_reg;
            resid_out_reg <= s2_resid_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign embedding_value = emb_reg;
    assign element_index   = idx_out_reg[OUT_IDX_W-1:0];
    assign token_end       = tend_reg;
    assign fired_total     = total_out_reg;
    assign residual        = resid_out_reg;

endmodule

FILE: hw/rtl/cif_integrate_and_fire.sv
// ---------------------------------------------------------------------------
// cif_integrate_and_fire
// Continuous integrate-and-fire aggregation of encoder frames, one hidden
// element per transaction, into fired acoustic embedding elements.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one hidden element per transaction: alpha and value in
//   tdata, frame_end as tlast, restart as tuser. m_axis returns one
//   transaction for each element of a frame that fires, none otherwise;
//   tlast marks the last element of the fired embedding.
//   The cfg channel writes the four registers (threshold, left mask, right
//   mask, frames per chunk); cfg_ready is always high. Write only when idle.
// Timing:
//   One element is accepted every cycle unless a firing result waits on a
//   stalled m_axis. A result reaches m_axis through the input register, the
//   multiply stage with the pending-store read, then accumulate and result register.
//   The integral and fired sum are updated at acceptance, so back-to-back
//   frames see each other's state without stalling.
// Reset and stalls:
//   rst_n clears the pipeline, the scalar state and the store's fill count;
//   no clearing pass is needed, so the block is ready right after reset.
//   A stalled m_axis holds the result; one non-firing element still passes
//   per cycle, and a firing element waits, backing up to s_axis_tready.
// ---------------------------------------------------------------------------
module cif_integrate_and_fire #(
    parameter int HIDDEN_SIZE = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: alpha_weight[15:0], hidden_value[31:16], frame_pos[39:32]
    input  logic [cif_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tlast,   // frame_end
    input  logic                                 s_axis_tuser,   // restart
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: embedding_value[39:0], element_index[48:40], fired_total[80:49],
    //        residual[99:81], zero[103:100]
    output logic [cif_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,   // token_end
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cif_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cif_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import cif_pkg::*;

    localparam int IDX_W  = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int FILL_W = $clog2(HIDDEN_SIZE + 1);

    cif_cfg_t                  cfg_reg;

    logic                      s1_valid, s1_advance;
    cif_item_t                 s1_item;
    logic [IDX_W-1:0]          s1_idx;

    logic signed [EMB_W-1:0]   embedding_value;
    logic [OUT_IDX_W-1:0]      element_index;
    logic [TOTAL_W-1:0]        fired_total;
    logic signed [INTEG_W-1:0] residual;

    // configuration registers, taken on every cfg transaction
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fire_threshold <= THR_W'(16384);
            cfg_reg.left_masked    <= '0;
            cfg_reg.right_masked   <= '0;
            cfg_reg.chunk_frames   <= CHUNK_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIRE_THRESHOLD: cfg_reg.fire_threshold <= cfg_data[THR_W-1:0];
                REG_LEFT_MASKED:    cfg_reg.left_masked    <= cfg_data[MASK_W-1:0];
                REG_RIGHT_MASKED:   cfg_reg.right_masked   <= cfg_data[MASK_W-1:0];
                REG_CHUNK_FRAMES:   cfg_reg.chunk_frames   <= cfg_data[CHUNK_W-1:0];
                default:            ;
            endcase
        end
    end

    // scalar decision and state; stage 1 register
    cif_front #(
        .HIDDEN_SIZE (HIDDEN_SIZE),
        .IDX_W       (IDX_W),
        .FILL_W      (FILL_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .alpha_weight (s_axis_tdata[15:0]),
        .hidden_value ($signed(s_axis_tdata[31:16])),
        .frame_pos    (s_axis_tdata[39:32]),
        .frame_end    (s_axis_tlast),
        .restart      (s_axis_tuser),
        .s1_advance   (s1_advance),
        .s1_valid     (s1_valid),
        .s1_item      (s1_item),
        .s1_idx       (s1_idx)
    );

    // pending store, multiply-accumulate and result register
    cif_mac #(
        .HIDDEN_SIZE (HIDDEN_SIZE),
        .IDX_W       (IDX_W)
    ) u_mac (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid),
        .s1_item         (s1_item),
        .s1_idx          (s1_idx),
        .s1_advance      (s1_advance),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .embedding_value (embedding_value),
        .element_index   (element_index),
        .token_end       (m_axis_tlast),
        .fired_total     (fired_total),
        .residual        (residual)
    );

    assign m_axis_tdata = {4'b0000, residual, fired_total, element_index, embedding_value};

`ifndef SYNTH
    // a fire leaves a non-negative integral
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[99])
        else $error("fired result with negative residual");

    // an empty input register never holds off the source
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid |-> s_axis_tready)
        else $error("input stalled with stage 1 empty");

    // emitted element index stays inside the hidden dimension
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ({4'b0000, m_axis_tdata[48:40]} < 13'(HIDDEN_SIZE)))
        else $error("element index beyond hidden size");
`endif

endmodule

FILE: sim/tb_cif_integrate_and_fire.sv
// ---------------------------------------------------------------------------
// tb_cif_integrate_and_fire
// Self-checking bench for the integrate-and-fire aggregation block: a burst
// driver feeds hidden elements, a bit-true predictor updates its own integral,
// fired sum and pending store at each accepted transaction, and a stalling
// monitor compares every fired embedding element against the oldest forecast.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cif_integrate_and_fire;

    import cif_pkg::*;

    localparam int HIDDEN = 512;

    // saturation bounds of the sums carried by the block
    localparam longint EMB_HI   = 64'sd549755813887;
    localparam longint EMB_LO   = -64'sd549755813888;
    localparam longint INTEG_HI = 64'sd262143;
    localparam longint INTEG_LO = -64'sd262144;
    localparam longint TOTAL_HI = 64'sd4294967295;

    // one hidden element as it is offered on s_axis
    typedef struct {
        logic [15:0]        alpha_weight;
        logic signed [15:0] hidden_value;
        logic [7:0]         frame_pos;
        logic               frame_end;
        logic               restart;
    } hidden_elem_t;

    // one fired embedding element as it should appear on m_axis
    typedef struct {
        logic [39:0] embedding;
        logic [8:0]  element_index;
        logic        token_end;
        logic [31:0] fired_total;
        logic [18:0] residual;
    } fired_elem_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cif_integrate_and_fire #(
        .HIDDEN_SIZE (HIDDEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor state: shadow registers and the block's own state
    // -----------------------------------------------------------------------
    int     thr_cfg;
    int     left_cfg;
    int     right_cfg;
    int     chunk_cfg;
    longint pend_acc [HIDDEN];
    longint integral;
    longint fired_sum;
    int     elem_count;

    hidden_elem_t feed_q [$];   // elements waiting for the driver
    fired_elem_t  fired_q [$];  // fired elements still to come out

    int  errors = 0;
    int  elems_accepted = 0;
    int  results_checked = 0;
    int  cfg_writes = 0;

    function automatic longint clamp_sum(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void clear_state();
        foreach (pend_acc[i])
            pend_acc[i] = 0;
        integral   = 0;
        fired_sum  = 0;
        elem_count = 0;
    endfunction

    // One accepted element: masking, integrate or fire, state update.
    // A fire appends the expected embedding element to fired_q.
    function automatic void integrate_element(hidden_elem_t e);
        longint      a;
        longint      h;
        longint      thr;
        longint      sum;
        longint      need;
        longint      resid;
        longint      emb;
        longint      total;
        int          idx;
        fired_elem_t fe;
        a   = e.alpha_weight;
        h   = e.hidden_value;
        thr = thr_cfg;
        if (e.restart)
            clear_state();
        // edge masking of the chunk; right edge only when the chunk is wider
        if (int'(e.frame_pos) < left_cfg)
            a = 0;
        if (chunk_cfg > right_cfg && int'(e.frame_pos) >= chunk_cfg - right_cfg)
            a = 0;
        idx = elem_count;
        sum = integral + a;
        if (sum < thr)
        begin
            pend_acc[idx] = clamp_sum(pend_acc[idx] + a * h, EMB_LO, EMB_HI);
            if (e.frame_end)
                integral = clamp_sum(sum, INTEG_LO, INTEG_HI);
        end
        else
        begin
            // need goes negative once the integral sits above the threshold
            need  = thr - integral;
            resid = clamp_sum(sum - thr, INTEG_LO, INTEG_HI);
            emb   = clamp_sum(pend_acc[idx] + need * h, EMB_LO, EMB_HI);
            total = clamp_sum(fired_sum + need, 0, TOTAL_HI);
            pend_acc[idx]    = clamp_sum(resid * h, EMB_LO, EMB_HI);
            fe.embedding     = emb[39:0];
            fe.element_index = idx[8:0];
            fe.token_end     = e.frame_end;
            fe.fired_total   = total[31:0];
            fe.residual      = resid[18:0];
            fired_q.insert(fired_q.size(), fe);
            if (e.frame_end)
            begin
                fired_sum = total;
                integral  = resid;
            end
        end
        // counter restarts at frame end and wraps after a full hidden vector
        if (e.frame_end || idx + 1 >= HIDDEN)
            elem_count = 0;
        else
            elem_count = idx + 1;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (errors < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // -----------------------------------------------------------------------
    // Driver: bursts of random length, random gaps; forecasts on acceptance
    // -----------------------------------------------------------------------
    hidden_elem_t cur_elem;
    int           burst_left;
    int           gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            s_axis_tuser  <= 1'b0;
            burst_left = $urandom_range(1, 30);
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                integrate_element(cur_elem);
                elems_accepted++;
            end
            // load the next element only when the slot is free
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (feed_q.size() > 0)
                begin
                    cur_elem = feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_elem.frame_pos, cur_elem.hidden_value,
                                      cur_elem.alpha_weight};
                    s_axis_tlast  <= cur_elem.frame_end;
                    s_axis_tuser  <= cur_elem.restart;
                    if (burst_left <= 1)
                    begin
                        // now and then a long stretch with no gaps at all
                        burst_left = ($urandom_range(0, 5) == 0) ? 120
                                                                 : $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 4);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: checks each result transaction, then picks the next ready
    // -----------------------------------------------------------------------
    int          ready_left;
    int          stall_left;
    fired_elem_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (fired_q.size() == 0)
                    flag_mismatch("fired element with none expected");
                else
                begin
                    want = fired_q.pop_front();
                    results_checked++;
                    if (m_axis_tdata[39:0] !== want.embedding)
                        flag_mismatch($sformatf("embedding got %h want %h",
                                                m_axis_tdata[39:0], want.embedding));
                    if (m_axis_tdata[48:40] !== want.element_index)
                        flag_mismatch($sformatf("element_index got %0d want %0d",
                                                m_axis_tdata[48:40], want.element_index));
                    if (m_axis_tlast !== want.token_end)
                        flag_mismatch($sformatf("token_end got %b want %b",
                                                m_axis_tlast, want.token_end));
                    if (m_axis_tdata[80:49] !== want.fired_total)
                        flag_mismatch($sformatf("fired_total got %h want %h",
                                                m_axis_tdata[80:49], want.fired_total));
                    if (m_axis_tdata[99:81] !== want.residual)
                        flag_mismatch($sformatf("residual got %h want %h",
                                                m_axis_tdata[99:81], want.residual));
                end
            end
            // stall pattern: a ready run, then a stall run (sometimes none)
            if (ready_left > 0)
            begin
                ready_left--;
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                ready_left = $urandom_range(1, 12);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic queue_elem(input int alpha, input int hidden, input int pos,
                              input bit fend, input bit rst);
        hidden_elem_t e;
        e.alpha_weight = alpha[15:0];
        e.hidden_value = hidden[15:0];
        e.frame_pos    = pos[7:0];
        e.frame_end    = fend;
        e.restart      = rst;
        feed_q.insert(feed_q.size(), e);
    endtask

    function automatic int pick_alpha();
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 65535;
            2: v = $urandom_range(0, 65535);
            3: v = $urandom_range(0, thr_cfg / 3);
            4: v = thr_cfg + int'($urandom_range(0, 80)) - 40;
            default: v = $urandom_range(0, thr_cfg);
        endcase
        return int'(clamp_sum(v, 0, 65535));
    endfunction

    function automatic int pick_hidden();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // positions cluster around both mask edges
    function automatic int pick_pos();
        int p;
        case ($urandom_range(0, 3))
            0: p = $urandom_range(0, 255);
            1: p = left_cfg + int'($urandom_range(0, 4)) - 2;
            2: p = chunk_cfg - right_cfg + int'($urandom_range(0, 4)) - 2;
            default: p = $urandom_range(0, (chunk_cfg > 1) ? chunk_cfg - 1 : 0);
        endcase
        return int'(clamp_sum(p, 0, 255));
    endfunction

    // Whole frames with random content; alpha mostly constant per frame
    task automatic queue_random_frames(input int n_items);
        int pushed;
        int len;
        int pos;
        int base_alpha;
        bit rst_first;
        pushed = 0;
        while (pushed < n_items)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            base_alpha = pick_alpha();
            pos        = pick_pos();
            rst_first  = ($urandom_range(0, 29) == 0);
            for (int k = 0; k < len; k++)
                queue_elem(($urandom_range(0, 7) == 0) ? pick_alpha() : base_alpha,
                           pick_hidden(), pos, k == len - 1, rst_first && k == 0);
            pushed += len;
        end
    endtask

    // Drained means: nothing queued or offered, nothing forecast, and the
    // three-stage pipe given time to retire non-firing elements too
    task automatic wait_idle();
        while (feed_q.size() != 0 || s_axis_tvalid || fired_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] reg_idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= value[15:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (reg_idx)
            REG_FIRE_THRESHOLD: thr_cfg   = value & 16'hFFFF;
            REG_LEFT_MASKED:    left_cfg  = value & 8'hFF;
            REG_RIGHT_MASKED:   right_cfg = value & 8'hFF;
            REG_CHUNK_FRAMES:   chunk_cfg = value & 9'h1FF;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_setting(input int thr, input int lm, input int rm, input int chunk);
        wait_idle();
        cfg_write(REG_FIRE_THRESHOLD, thr);
        cfg_write(REG_LEFT_MASKED, lm);
        cfg_write(REG_RIGHT_MASKED, rm);
        cfg_write(REG_CHUNK_FRAMES, chunk);
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        thr_cfg   = 16384;
        left_cfg  = 0;
        right_cfg = 0;
        chunk_cfg = 64;
        clear_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings (positions 64 and up fall in the right mask)
        // integrate without firing, hidden extremes
        queue_elem(5000, 32767, 0, 1'b0, 1'b1);
        queue_elem(5000, -32768, 0, 1'b0, 1'b0);
        queue_elem(5000, 0, 0, 1'b1, 1'b0);
        // crosses the threshold: both elements fire, residual carried on
        queue_elem(12000, 4096, 10, 1'b0, 1'b0);
        queue_elem(12000, -4096, 10, 1'b1, 1'b0);
        // masked at the right edge, top position
        queue_elem(65535, 32767, 255, 1'b1, 1'b0);
        // differing alphas inside one frame
        queue_elem(65535, -32768, 1, 1'b0, 1'b0);
        queue_elem(0, 12345, 1, 1'b0, 1'b0);
        queue_elem(20000, -1, 1, 1'b1, 1'b0);
        // restart, then a sum landing exactly on the threshold
        queue_elem(16384, 1, 2, 1'b1, 1'b1);
        queue_elem(0, -1, 3, 1'b1, 1'b0);
        queue_elem(16383, 32767, 63, 1'b1, 1'b1);
        queue_elem(1, -32768, 63, 1'b1, 1'b0);
        queue_random_frames(110);

        // everything masked: left mask covers 0..254, right mask the rest
        apply_setting(65535, 255, 255, 256);
        queue_random_frames(30);

        // tiny threshold: constant firing, integral climbs to saturation and
        // sits far above the threshold, fired sum pinned at zero
        apply_setting(1, 2, 3, 16);
        for (int k = 0; k < 6; k++)
            queue_elem(65535, pick_hidden(), 8, 1'b1, 1'b0);
        queue_random_frames(110);

        // threshold still below the inherited integral; right mask inactive
        apply_setting(40000, 0, 255, 255);
        queue_random_frames(80);

        apply_setting($urandom_range(1, 65535), $urandom_range(0, 8),
                      $urandom_range(0, 8), $urandom_range(8, 64));
        queue_random_frames(110);

        // single-frame chunks: right mask equals the chunk width, so it is inactive
        apply_setting($urandom_range(1, 65535), 0, 1, 1);
        queue_random_frames(100);

        wait_idle();
        $display("ran %0d hidden elements, %0d fired embedding elements checked",
                 elems_accepted, results_checked);
        $display("%0d register writes: masks, tiny and full thresholds, sum clipping",
                 cfg_writes);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("watchdog expired with %0d fired elements outstanding", fired_q.size());
        $display("status: fail");
        $finish;
    end

endmodule
